### hw/rtl/mci_pkg.sv
// ----------------------------------------------------------------------------
// mci_pkg
// Shared constants, types and SHA-256 helpers for the mnemonic indexer.
// ----------------------------------------------------------------------------
package mci_pkg;

  localparam int MAX_ENTROPY_BYTES_DEF = 32;
  localparam int INDEX_BITS_DEF        = 11;
  localparam int QUEUE_DEPTH           = 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HASH,
    PH_EMIT
  } phase_t;

  // one queued job: the byte count of a completed load
  typedef struct packed {
    logic [5:0] nbytes;
  } job_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### hw/rtl/mci_front.sv
// ----------------------------------------------------------------------------
// mci_front
// Loads entropy bytes into the store and posts a job when a load completes.
// ----------------------------------------------------------------------------
module mci_front
  import mci_pkg::*;
#(
  parameter int MAX_BYTES = MAX_ENTROPY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] length_mode,
  input  logic       in_valid,
  input  logic [7:0] entropy_byte,
  output logic       in_stall,
  input  logic       job_full,
  output logic       job_push,
  output job_t       job,
  output logic       wr_en,
  output logic [$clog2(MAX_BYTES)-1:0] wr_addr,
  output logic [7:0] wr_data
);

  localparam int AW = $clog2(MAX_BYTES);

  logic [5:0] load_count;
  logic [5:0] nbytes;
  logic [5:0] pos;
  logic       fire;
  logic       last;

  always_comb begin
    if (length_mode == 2'd0) nbytes = 6'd16;
    else if (length_mode == 2'd1 || MAX_BYTES < 32) nbytes = (MAX_BYTES < 24) ? 6'd16 : 6'd24;
    else nbytes = 6'd32;
  end

  // a shrunk length clamps onto its last byte
  assign pos      = (load_count > nbytes - 6'd1) ? nbytes - 6'd1 : load_count;
  assign last     = (pos == nbytes - 6'd1);
  // hold the completing byte until the queue has room
  assign in_stall = last && job_full;
  assign fire     = in_valid && !in_stall;
  assign wr_en    = fire;
  assign wr_addr  = pos[AW-1:0];
  assign wr_data  = entropy_byte;
  assign job_push = fire && last;
  assign job.nbytes = nbytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (fire) begin
      load_count <= last ? 6'd0 : pos + 6'd1;
    end
  end

endmodule

### hw/rtl/mci_queue.sv
// ----------------------------------------------------------------------------
// mci_queue
// Short job queue between loader and hash/emit engine.
// ----------------------------------------------------------------------------
module mci_queue
  import mci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       slots [QUEUE_DEPTH];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(QUEUE_DEPTH));
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/mci_back.sv
// ----------------------------------------------------------------------------
// mci_back
// Runs one SHA-256 round a cycle over the padded block, then emits indices.
// ----------------------------------------------------------------------------
module mci_back
  import mci_pkg::*;
#(
  parameter int MAX_BYTES  = MAX_ENTROPY_BYTES_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_empty,
  input  job_t       job,
  output logic       job_pop,
  input  logic       wr_en,
  input  logic [$clog2(MAX_BYTES)-1:0] wr_addr,
  input  logic [7:0] wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [INDEX_BITS-1:0] word_index,
  output logic       last_word
);

  localparam int BW = MAX_BYTES * 8 + 8;

  // entropy store: flops, since the block load reads all of it at once
  logic [7:0]  store [MAX_BYTES];
  logic [31:0] sched [16];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [6:0]  round_number;
  logic [4:0]  emit_count;
  logic [4:0]  words;
  logic [5:0]  nbytes;
  logic [BW-1:0] bits;
  logic [8:0]  bit_ptr;
  phase_t      phase, phase_next;
  logic        start, hash_done;
  logic        emit_adv;

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
  end

  // padded block word i
  function automatic logic [31:0] blk_word(input int i, input logic [5:0] n);
    logic [31:0] w;
    int          j;
    w = '0;
    for (j = 0; j < 4; j++) begin
      if (4 * i + j < MAX_BYTES && 6'(4 * i + j) < n)
        w[31-8*j -: 8] = store[4 * i + j];
      else if (6'(4 * i + j) == n)
        w[31-8*j -: 8] = 8'h80;
    end
    if (i == 15) w = {23'd0, n, 3'd0};
    return w;
  endfunction

  logic [31:0] w_cur, w15, w2, g0, g1, s0, s1, ch, maj, t1, t2;
  logic [3:0]  r4;

  assign r4  = round_number[3:0];
  assign w15 = sched[r4 + 4'd1];
  assign w2  = sched[r4 + 4'd14];
  assign g0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign g1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign w_cur = (round_number < 7'd16) ? sched[r4]
               : sched[r4] + g0 + sched[r4 + 4'd9] + g1;
  assign s1  = rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25);
  assign ch  = (ve & vf) ^ (~ve & vg);
  assign t1  = vh + s1 + ch + round_k(round_number[5:0]) + w_cur;
  assign s0  = rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22);
  assign maj = (va & vb) ^ (va & vc) ^ (vb & vc);
  assign t2  = s0 + maj;

  assign start     = (phase == PH_IDLE) && !job_empty;
  assign hash_done = (phase == PH_HASH) && (round_number == 7'd64);
  assign emit_adv  = (phase == PH_EMIT) && out_valid && !out_stall;
  assign job_pop   = start;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (start) phase_next = PH_HASH;
      PH_HASH: if (hash_done) phase_next = PH_EMIT;
      PH_EMIT: if (emit_adv && last_word) phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) phase <= PH_IDLE;
    else     phase <= phase_next;
  end

  logic [31:0] digest0;
  logic [3:0]  cs_len;
  assign digest0 = init_h(3'd0) + va;
  assign cs_len  = nbytes[5:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      round_number <= '0;
      emit_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (start) begin
        nbytes       <= job.nbytes;
        round_number <= '0;
        for (int i = 0; i < 16; i++) sched[i] <= blk_word(i, job.nbytes);
        va <= init_h(3'd0); vb <= init_h(3'd1); vc <= init_h(3'd2); vd <= init_h(3'd3);
        ve <= init_h(3'd4); vf <= init_h(3'd5); vg <= init_h(3'd6); vh <= init_h(3'd7);
      end else if (phase == PH_HASH && !hash_done) begin
        sched[r4] <= w_cur;
        vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
        vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
        round_number <= round_number + 7'd1;
      end
      if (hash_done) begin
        // entropy bits then checksum, left aligned
        for (int i = 0; i < BW / 8; i++)
          bits[BW-1-8*i -: 8] <= (i < MAX_BYTES && 6'(i) < nbytes) ? store[i]
                               : (6'(i) == nbytes)
                               ? (digest0[31:24] & (8'hff << (4'd8 - cs_len))) : 8'h00;
        // index count is three quarters of the byte count
        words        <= {1'b0, cs_len} + {cs_len, 1'b0};
        emit_count   <= '0;
        out_valid    <= 1'b1;
        round_number <= '0;
      end
      if (emit_adv) begin
        emit_count <= emit_count + 5'd1;
        bits       <= bits << INDEX_BITS;
        if (last_word) out_valid <= 1'b0;
      end
    end
  end

  assign bit_ptr    = 9'(BW - 1);
  assign word_index = bits[bit_ptr -: INDEX_BITS];
  assign last_word  = (emit_count + 5'd1 == words);

endmodule

### hw/rtl/mnemonic_checksum_indexer.sv
// ----------------------------------------------------------------------------
// mnemonic_checksum_indexer
// Entropy bytes in, SHA-256 checksummed eleven-bit word indices out.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | entropy_byte[7:0]
//  out     | out_valid/out_stall| word_index[10:0], last_word
//  cfg     | cfg_we/cfg_wdata   | length_mode[1:0]
//
// Bytes load one a cycle while in_stall is low. A completed load enters a
// two-deep job queue; the engine pops the job and loads the block, runs the
// hash rounds, packs, then emits one index per cycle (12, 18 or 24) while
// out_stall is low. The store holds only one load, so in_stall stays high
// from the cycle after the completing byte until the last index is taken.
// Reset is synchronous; out_stall holds the current index.
module mnemonic_checksum_indexer
  import mci_pkg::*;
#(
  parameter int MAX_ENTROPY_BYTES = MAX_ENTROPY_BYTES_DEF,
  parameter int INDEX_BITS        = INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] entropy_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [INDEX_BITS-1:0] word_index,
  output logic       last_word
);

  localparam int AW = $clog2(MAX_ENTROPY_BYTES);

  logic [1:0] length_mode;
  logic       q_full, q_empty, q_push, q_pop, f_stall, wr_en, busy;
  logic       engine_busy;
  job_t       push_job, head_job;
  logic [AW-1:0] wr_addr;
  logic [7:0] wr_data;

  always_ff @(posedge clk) begin
    if (rst) length_mode <= 2'd0;
    else if (cfg_we) length_mode <= cfg_wdata;
  end

  // stall new bytes while the engine still reads the store
  assign busy     = !q_empty || out_valid || q_pop;
  always_ff @(posedge clk) begin
    if (rst) engine_busy <= 1'b0;
    else if (q_push) engine_busy <= 1'b1;
    else if (out_valid && !out_stall && last_word) engine_busy <= 1'b0;
  end
  assign in_stall = f_stall || engine_busy || busy;

  mci_front #(.MAX_BYTES(MAX_ENTROPY_BYTES)) u_front (
    .clk, .rst, .length_mode,
    .in_valid(in_valid && !engine_busy && !busy), .entropy_byte,
    .in_stall(f_stall), .job_full(q_full), .job_push(q_push), .job(push_job),
    .wr_en, .wr_addr, .wr_data
  );

  mci_queue u_queue (
    .clk, .rst, .push(q_push), .push_job, .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(head_job)
  );

  mci_back #(.MAX_BYTES(MAX_ENTROPY_BYTES), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk, .rst, .job_empty(q_empty), .job(head_job), .job_pop(q_pop),
    .wr_en, .wr_addr, .wr_data,
    .out_valid, .out_stall, .word_index, .last_word
  );

endmodule
